FILE: hw/rtl/jrd_pkg.sv
// Shared types, constants and the CRC-32C byte update for the journal record deframer.
`timescale 1ns / 1ps
package jrd_pkg;

	// Widths of the fields and of the internal counters
	localparam int unsigned DATA_W  = 8;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned SEQ_W   = 64;
	localparam int unsigned LEN_W   = 24;
	localparam int unsigned CFG_W   = 32;
	localparam int unsigned CFG_IDX_W = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RECORD_MAGIC = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH   = 1'b1;

	// Configuration reset values
	localparam logic [WORD_W-1:0] MAGIC_RESET   = 32'h0000_0000;
	localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 24'h10_0000;

	// Header byte positions (count after the byte is taken)
	localparam logic [LEN_W-1:0] HDR_MAGIC_END = 24'd4;
	localparam logic [LEN_W-1:0] HDR_TYPE_END  = 24'd8;
	localparam logic [LEN_W-1:0] HDR_SEQ_END   = 24'd16;
	localparam logic [LEN_W-1:0] HDR_BYTES     = 24'd20;
	localparam logic [LEN_W-1:0] TRL_BYTES     = 24'd4;

	// CRC-32C, reflected
	localparam logic [WORD_W-1:0] CRC_SEED = 32'hFFFF_FFFF;
	localparam logic [WORD_W-1:0] CRC_POLY = 32'h82F6_3B78;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_TRAILER = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		KIND_PAYLOAD   = 3'd0,
		KIND_GOOD      = 3'd1,
		KIND_BAD_MAGIC = 3'd2,
		KIND_TOO_LONG  = 3'd3,
		KIND_CRC_ERR   = 3'd4,
		KIND_TRUNCATED = 3'd5,
		KIND_BUF_END   = 3'd6
	} kind_t;

	// One input byte with its end-of-buffer mark
	typedef struct packed {
		logic [DATA_W-1:0] data_byte;
		logic              end_of_buffer;
	} item_t;

	// One result
	typedef struct packed {
		kind_t             kind;
		logic [DATA_W-1:0] payload_byte;
		logic [WORD_W-1:0] record_type;
		logic [SEQ_W-1:0]  sequence_number;
		logic [LEN_W-1:0]  record_length;
		logic              buffer_done;
	} result_t;

	// Fold one byte into the running CRC-32C
	function automatic logic [WORD_W-1:0] crc32c_byte(input logic [WORD_W-1:0] crc,
			input logic [DATA_W-1:0] b);
		logic [WORD_W-1:0] c;
		c = crc ^ {{(WORD_W-DATA_W){1'b0}}, b};
		for (int i = 0; i < DATA_W; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

FILE: hw/rtl/jrd_in_if.sv
// Byte channel: valid/ready handshake carrying one buffer byte per request.
`timescale 1ns / 1ps
interface jrd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_buffer;

	modport source (output valid, output data_byte, output end_of_buffer, input ready);
	modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

FILE: hw/rtl/jrd_out_if.sv
// Result channel: valid/ready handshake carrying one deframer result per request.
`timescale 1ns / 1ps
interface jrd_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  payload_byte;
	logic [31:0] record_type;
	logic [63:0] sequence_number;
	logic [23:0] record_length;
	logic        buffer_done;

	modport source (output valid, output kind, output payload_byte, output record_type,
		output sequence_number, output record_length, output buffer_done, input ready);
	modport sink (input valid, input kind, input payload_byte, input record_type,
		input sequence_number, input record_length, input buffer_done, output ready);
endinterface

FILE: hw/rtl/jrd_in_stage.sv
// Input register: captures one byte request and holds it until the parser advances.
`timescale 1ns / 1ps
module jrd_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	jrd_in_if.sink          byte_chan,
	input  logic            advance,
	output logic            valid_s1,
	output jrd_pkg::item_t  item_s1
);

	logic accept;

	// Take a new request when the register is empty or drains this cycle
	assign byte_chan.ready = !valid_s1 || advance;
	assign accept          = byte_chan.valid && byte_chan.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Hold the payload while stalled
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.data_byte     <= byte_chan.data_byte;
			item_s1.end_of_buffer <= byte_chan.end_of_buffer;
		end
	end

endmodule

FILE: hw/rtl/jrd_parser.sv
// Record parser: header, payload and trailer tracking with the running CRC-32C.
`timescale 1ns / 1ps
module jrd_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  jrd_pkg::item_t                item_s1,
	input  logic [jrd_pkg::WORD_W-1:0]    record_magic,
	input  logic [jrd_pkg::LEN_W-1:0]     max_payload_length,
	output logic                          have,
	output jrd_pkg::result_t              res
);

	jrd_pkg::phase_t               phase_q, phase_d;
	logic [jrd_pkg::LEN_W-1:0]     cnt_q, cnt_d, cnt_inc;
	logic [jrd_pkg::SEQ_W-1:0]     hdr_q, hdr_d;
	logic [jrd_pkg::WORD_W-1:0]    type_q, type_d;
	logic [jrd_pkg::LEN_W-1:0]     len_q, len_d;
	logic [jrd_pkg::WORD_W-1:0]    crc_q, crc_d, crc_upd;
	logic [jrd_pkg::WORD_W-1:0]    trl_q, trl_d;
	logic                          stop_q, stop_d;
	logic [jrd_pkg::WORD_W-1:0]    trl_word, hdr_word;
	logic [jrd_pkg::DATA_W-1:0]    b;

	assign b        = item_s1.data_byte;
	assign cnt_inc  = cnt_q + jrd_pkg::LEN_W'(1);
	assign trl_word = {trl_q[jrd_pkg::WORD_W-jrd_pkg::DATA_W-1:0], b};
	assign hdr_word = {hdr_q[jrd_pkg::WORD_W-jrd_pkg::DATA_W-1:0], b};
	assign crc_upd  = jrd_pkg::crc32c_byte(crc_q, b);

	// Next state and result for the byte in the input register
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		hdr_d   = hdr_q;
		type_d  = type_q;
		len_d   = len_q;
		crc_d   = crc_q;
		trl_d   = trl_q;
		stop_d  = stop_q;
		have    = 1'b0;
		res     = '0;
		res.kind = jrd_pkg::KIND_PAYLOAD;

		if (!stop_q) begin
			case (phase_q)
				jrd_pkg::PH_HEADER: begin
					crc_d = crc_upd;
					cnt_d = cnt_inc;
					if (cnt_inc <= jrd_pkg::HDR_SEQ_END) begin
						hdr_d = {hdr_q[jrd_pkg::SEQ_W-jrd_pkg::DATA_W-1:0], b};
					end else begin
						trl_d = trl_word;
					end
					if (cnt_inc == jrd_pkg::HDR_MAGIC_END) begin
						// check magic as soon as it is complete
						if (hdr_word != record_magic) begin
							have     = 1'b1;
							res.kind = jrd_pkg::KIND_BAD_MAGIC;
							stop_d   = 1'b1;
						end
					end else if (cnt_inc == jrd_pkg::HDR_TYPE_END) begin
						type_d = hdr_word;
					end else if (cnt_inc == jrd_pkg::HDR_BYTES) begin
						// full 32-bit length against the limit
						if (trl_word > {{(jrd_pkg::WORD_W-jrd_pkg::LEN_W){1'b0}},
								max_payload_length}) begin
							have     = 1'b1;
							res.kind = jrd_pkg::KIND_TOO_LONG;
							stop_d   = 1'b1;
						end else begin
							len_d   = trl_word[jrd_pkg::LEN_W-1:0];
							trl_d   = '0;
							cnt_d   = '0;
							phase_d = (trl_word[jrd_pkg::LEN_W-1:0] != '0) ?
								jrd_pkg::PH_PAYLOAD : jrd_pkg::PH_TRAILER;
						end
					end
				end
				jrd_pkg::PH_PAYLOAD: begin
					crc_d            = crc_upd;
					have             = 1'b1;
					res.kind         = jrd_pkg::KIND_PAYLOAD;
					res.payload_byte = b;
					cnt_d            = cnt_inc;
					if (cnt_inc >= len_q) begin
						cnt_d   = '0;
						phase_d = jrd_pkg::PH_TRAILER;
					end
				end
				default: begin
					trl_d = trl_word;
					cnt_d = cnt_inc;
					if (cnt_inc >= jrd_pkg::TRL_BYTES) begin
						have = 1'b1;
						if (~crc_q == trl_word) begin
							res.kind            = jrd_pkg::KIND_GOOD;
							res.record_type     = type_q;
							res.sequence_number = hdr_q;
							res.record_length   = len_q;
							phase_d = jrd_pkg::PH_HEADER;
							cnt_d   = '0;
							hdr_d   = '0;
							trl_d   = '0;
							crc_d   = jrd_pkg::CRC_SEED;
						end else begin
							res.kind = jrd_pkg::KIND_CRC_ERR;
							stop_d   = 1'b1;
						end
					end
				end
			endcase
		end

		// Last byte: report truncation or buffer end, then start fresh
		if (item_s1.end_of_buffer) begin
			if (!stop_d && (phase_d != jrd_pkg::PH_HEADER || cnt_d != '0)) begin
				res      = '0;
				res.kind = jrd_pkg::KIND_TRUNCATED;
				have     = 1'b1;
			end else if (!have) begin
				res      = '0;
				res.kind = jrd_pkg::KIND_BUF_END;
				have     = 1'b1;
			end
			res.buffer_done = 1'b1;
			phase_d = jrd_pkg::PH_HEADER;
			cnt_d   = '0;
			hdr_d   = '0;
			type_d  = '0;
			len_d   = '0;
			crc_d   = jrd_pkg::CRC_SEED;
			trl_d   = '0;
			stop_d  = 1'b0;
		end
	end

	// Advance parser state once per byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= jrd_pkg::PH_HEADER;
			cnt_q   <= '0;
			hdr_q   <= '0;
			type_q  <= '0;
			len_q   <= '0;
			crc_q   <= jrd_pkg::CRC_SEED;
			trl_q   <= '0;
			stop_q  <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			hdr_q   <= hdr_d;
			type_q  <= type_d;
			len_q   <= len_d;
			crc_q   <= crc_d;
			trl_q   <= trl_d;
			stop_q  <= stop_d;
		end
	end

endmodule

FILE: hw/rtl/jrd_out_stage.sv
// Result register: holds one result request until the consumer takes it.
`timescale 1ns / 1ps
module jrd_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic             have,
	input  jrd_pkg::result_t res,
	output logic             free,
	jrd_out_if.source        result_chan
);

	logic             valid_q;
	jrd_pkg::result_t res_q;

	// Free when empty or being taken this cycle
	assign free = !valid_q || result_chan.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= have;
		end else if (result_chan.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && have) begin
			res_q <= res;
		end
	end

	// Drive the channel
	assign result_chan.valid           = valid_q;
	assign result_chan.kind            = res_q.kind;
	assign result_chan.payload_byte    = res_q.payload_byte;
	assign result_chan.record_type     = res_q.record_type;
	assign result_chan.sequence_number = res_q.sequence_number;
	assign result_chan.record_length   = res_q.record_length;
	assign result_chan.buffer_done     = res_q.buffer_done;

endmodule

FILE: hw/rtl/journal_record_deframer_unit.sv
// Top level of the journal record deframer: config registers, input, parser and result stages.
//
//   channel      dir  width  carries
//   byte_chan    in   9      data_byte, end_of_buffer
//   result_chan  out  132    kind, payload_byte, record_type, sequence_number,
//                            record_length, buffer_done
//   cfg_*        in   34     write enable, register index, write data
//
// One byte per cycle sustained while results are taken; a result passes the input
// register, then the result register, and is offered from the latter, limited
// by the byte-wide CRC-32C update between them. Reset clears parser state and
// loads the register defaults. A stalled result holds the input register,
// which still takes one further byte if it is empty.
`timescale 1ns / 1ps
module journal_record_deframer_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	jrd_in_if.sink                           byte_chan,
	jrd_out_if.source                        result_chan,
	input  logic                             cfg_we,
	input  logic [jrd_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [jrd_pkg::CFG_W-1:0]        cfg_wdata
);

	logic [jrd_pkg::WORD_W-1:0] magic_q;
	logic [jrd_pkg::LEN_W-1:0]  max_len_q;
	logic                       valid_s1;
	jrd_pkg::item_t             item_s1;
	logic                       advance;
	logic                       out_free;
	logic                       have;
	jrd_pkg::result_t           res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q   <= jrd_pkg::MAGIC_RESET;
			max_len_q <= jrd_pkg::MAX_LEN_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				jrd_pkg::CFG_RECORD_MAGIC: magic_q   <= cfg_wdata[jrd_pkg::WORD_W-1:0];
				jrd_pkg::CFG_MAX_LENGTH:   max_len_q <= cfg_wdata[jrd_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Move the held byte when the result register can take its outcome
	assign advance = valid_s1 && out_free;

	jrd_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_chan (byte_chan),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	jrd_parser u_parser (
		.clk                (clk),
		.arst_n             (arst_n),
		.advance            (advance),
		.item_s1            (item_s1),
		.record_magic       (magic_q),
		.max_payload_length (max_len_q),
		.have               (have),
		.res                (res)
	);

	jrd_out_stage u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance),
		.have        (have),
		.res         (res),
		.free        (out_free),
		.result_chan (result_chan)
	);

endmodule

FILE: tb/sv/journal_record_deframer_unit_tb.sv
// Self-checking testbench for the journal record deframer: directed and random byte streams.
`timescale 1ns / 1ps
module journal_record_deframer_unit_tb;

	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 4;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [jrd_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [jrd_pkg::CFG_W-1:0] cfg_wdata;

	jrd_in_if byte_if ();
	jrd_out_if res_if ();

	journal_record_deframer_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_chan   (byte_if),
		.result_chan (res_if),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predicted registers and parser state
	logic [jrd_pkg::WORD_W-1:0] pr_magic;
	logic [jrd_pkg::LEN_W-1:0]  pr_max;
	jrd_pkg::phase_t            pr_phase;
	logic [jrd_pkg::LEN_W-1:0]  pr_count;
	logic [jrd_pkg::SEQ_W-1:0]  pr_hdr;
	logic [jrd_pkg::WORD_W-1:0] pr_type;
	logic [jrd_pkg::LEN_W-1:0]  pr_len;
	logic [jrd_pkg::WORD_W-1:0] pr_crc;
	logic [jrd_pkg::WORD_W-1:0] pr_tail;
	logic                       pr_halted;

	jrd_pkg::result_t pending_results[$];
	logic [7:0] frame_q[$];

	int tx_idle_pct;
	int rx_idle_pct;
	int hold_ticket;
	int hold_served;
	int hold_left;
	int bad_results;
	int bytes_in;
	int input_stalls;
	int kind_count[7];

	// Fold one byte into a reflected CRC-32C
	function automatic logic [31:0] crc32c_step(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] v;
		v = c ^ {24'h0, b};
		for (int i = 0; i < 8; i++) begin
			if (v[0])
				v = (v >> 1) ^ jrd_pkg::CRC_POLY;
			else
				v = v >> 1;
		end
		return v;
	endfunction

	function automatic void clear_parser();
		pr_phase = jrd_pkg::PH_HEADER;
		pr_count = '0;
		pr_hdr = '0;
		pr_type = '0;
		pr_len = '0;
		pr_crc = jrd_pkg::CRC_SEED;
		pr_tail = '0;
		pr_halted = 1'b0;
	endfunction

	// Advance the parser by one accepted byte and queue the result it causes
	function automatic void deframe_byte(input logic [7:0] b, input logic e);
		jrd_pkg::result_t r;
		logic have;
		r = '0;
		have = 1'b0;
		if (!pr_halted) begin
			case (pr_phase)
				jrd_pkg::PH_HEADER: begin
					pr_crc = crc32c_step(pr_crc, b);
					pr_count = pr_count + 1'b1;
					if (pr_count <= jrd_pkg::HDR_SEQ_END)
						pr_hdr = {pr_hdr[55:0], b};
					else
						pr_tail = {pr_tail[23:0], b};
					if (pr_count == jrd_pkg::HDR_MAGIC_END) begin
						if (pr_hdr[31:0] != pr_magic) begin
							r.kind = jrd_pkg::KIND_BAD_MAGIC;
							have = 1'b1;
							pr_halted = 1'b1;
						end
					end else if (pr_count == jrd_pkg::HDR_TYPE_END) begin
						pr_type = pr_hdr[31:0];
					end else if (pr_count == jrd_pkg::HDR_BYTES) begin
						// full 32-bit length word against the limit
						if (pr_tail > {8'h00, pr_max}) begin
							r.kind = jrd_pkg::KIND_TOO_LONG;
							have = 1'b1;
							pr_halted = 1'b1;
						end else begin
							pr_len = pr_tail[23:0];
							pr_tail = '0;
							pr_count = '0;
							pr_phase = (pr_len != 0) ? jrd_pkg::PH_PAYLOAD :
								jrd_pkg::PH_TRAILER;
						end
					end
				end
				jrd_pkg::PH_PAYLOAD: begin
					pr_crc = crc32c_step(pr_crc, b);
					r.kind = jrd_pkg::KIND_PAYLOAD;
					r.payload_byte = b;
					have = 1'b1;
					pr_count = pr_count + 1'b1;
					if (pr_count >= pr_len) begin
						pr_count = '0;
						pr_phase = jrd_pkg::PH_TRAILER;
					end
				end
				default: begin
					pr_tail = {pr_tail[23:0], b};
					pr_count = pr_count + 1'b1;
					if (pr_count >= jrd_pkg::TRL_BYTES) begin
						if (~pr_crc == pr_tail) begin
							r.kind = jrd_pkg::KIND_GOOD;
							r.record_type = pr_type;
							r.sequence_number = pr_hdr;
							r.record_length = pr_len;
							have = 1'b1;
							pr_phase = jrd_pkg::PH_HEADER;
							pr_count = '0;
							pr_hdr = '0;
							pr_tail = '0;
							pr_crc = jrd_pkg::CRC_SEED;
						end else begin
							r.kind = jrd_pkg::KIND_CRC_ERR;
							have = 1'b1;
							pr_halted = 1'b1;
						end
					end
				end
			endcase
		end
		// Last byte: report an unfinished record or the plain end, then start fresh
		if (e) begin
			if (!pr_halted && (pr_phase != jrd_pkg::PH_HEADER || pr_count != 0)) begin
				r = '0;
				r.kind = jrd_pkg::KIND_TRUNCATED;
				have = 1'b1;
			end else if (!have) begin
				r.kind = jrd_pkg::KIND_BUF_END;
				have = 1'b1;
			end
			r.buffer_done = 1'b1;
			clear_parser();
		end
		if (have)
			pending_results.push_back(r);
	endfunction

	// Compare one accepted result with the oldest prediction
	function automatic void check_result();
		jrd_pkg::result_t want;
		jrd_pkg::result_t got;
		logic bad;
		got.kind = jrd_pkg::kind_t'(res_if.kind);
		got.payload_byte = res_if.payload_byte;
		got.record_type = res_if.record_type;
		got.sequence_number = res_if.sequence_number;
		got.record_length = res_if.record_length;
		got.buffer_done = res_if.buffer_done;
		if (pending_results.size() == 0) begin
			$display("%0t: result with none expected, kind %0d", $time, got.kind);
			bad_results++;
			return;
		end
		want = pending_results.pop_front();
		kind_count[want.kind]++;
		bad = 1'b0;
		if (got.kind !== want.kind) begin
			$display("%0t: kind expected %0d got %0d", $time, want.kind, got.kind);
			bad = 1'b1;
		end
		if (got.payload_byte !== want.payload_byte) begin
			$display("%0t: payload_byte expected %h got %h", $time, want.payload_byte,
				got.payload_byte);
			bad = 1'b1;
		end
		if (got.record_type !== want.record_type) begin
			$display("%0t: record_type expected %h got %h", $time, want.record_type,
				got.record_type);
			bad = 1'b1;
		end
		if (got.sequence_number !== want.sequence_number) begin
			$display("%0t: sequence_number expected %h got %h", $time,
				want.sequence_number, got.sequence_number);
			bad = 1'b1;
		end
		if (got.record_length !== want.record_length) begin
			$display("%0t: record_length expected %h got %h", $time, want.record_length,
				got.record_length);
			bad = 1'b1;
		end
		if (got.buffer_done !== want.buffer_done) begin
			$display("%0t: buffer_done expected %b got %b", $time, want.buffer_done,
				got.buffer_done);
			bad = 1'b1;
		end
		if (bad)
			bad_results++;
	endfunction

	// Result side: check, count input stalls, drive ready with random or long holds
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			check_result();
		if (byte_if.valid && !byte_if.ready)
			input_stalls++;
		if (hold_ticket != hold_served) begin
			hold_served = hold_ticket;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= arst_n && ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Offer one byte, hold it until the request is taken, then predict
	task automatic send_byte(input logic [7:0] b, input logic e);
		while ($urandom_range(99) < tx_idle_pct) begin
			byte_if.valid <= 1'b0;
			@(posedge clk);
		end
		byte_if.valid <= 1'b1;
		byte_if.data_byte <= b;
		byte_if.end_of_buffer <= e;
		@(posedge clk);
		while (!byte_if.ready)
			@(posedge clk);
		bytes_in++;
		deframe_byte(b, e);
	endtask

	// Send the first upto bytes of the frame as one buffer, then drop the frame
	task automatic send_frame(input int upto);
		for (int i = 0; i < upto; i++)
			send_byte(frame_q[i], i == upto - 1);
		frame_q.delete();
	endtask

	// Append one record: header, payload and trailer (trailer bits flipped by flip)
	function automatic void add_record(input logic [31:0] mg, input logic [31:0] rt,
			input logic [63:0] sq, input logic [31:0] ln, input int npay,
			input logic [31:0] flip);
		logic [159:0] h;
		logic [31:0] c;
		logic [31:0] t;
		logic [7:0] b;
		h = {mg, rt, sq, ln};
		c = jrd_pkg::CRC_SEED;
		for (int i = 0; i < 20; i++) begin
			b = h[159 - 8 * i -: 8];
			c = crc32c_step(c, b);
			frame_q.push_back(b);
		end
		for (int i = 0; i < npay; i++) begin
			b = $urandom_range(255);
			c = crc32c_step(c, b);
			frame_q.push_back(b);
		end
		t = ~c ^ flip;
		for (int i = 0; i < 4; i++)
			frame_q.push_back(t[31 - 8 * i -: 8]);
	endfunction

	function automatic void add_noise(input int n);
		for (int i = 0; i < n; i++)
			frame_q.push_back($urandom_range(255));
	endfunction

	// Write a register once every expected result is out and the pipe has settled
	task automatic write_reg(input logic [jrd_pkg::CFG_IDX_W-1:0] idx,
			input logic [jrd_pkg::CFG_W-1:0] val);
		byte_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == jrd_pkg::CFG_RECORD_MAGIC)
			pr_magic = val;
		else
			pr_max = val[jrd_pkg::LEN_W-1:0];
	endtask

	function automatic int pick_len();
		int lim;
		lim = (pr_max > 12) ? 12 : int'(pr_max);
		if ($urandom_range(99) < 5)
			lim = (pr_max > 96) ? 96 : int'(pr_max);
		return $urandom_range(lim, 0);
	endfunction

	function automatic logic [31:0] too_long_len();
		if ($urandom_range(1))
			return {8'h00, pr_max} + 32'd1 + $urandom_range(2);
		return $urandom | 32'h0100_0000;
	endfunction

	// Mostly good records, ending at times in an error, noise or a cut
	task automatic random_buffer();
		int nrec;
		int sel;
		int npay;
		int cut;
		logic [31:0] mg;
		logic [31:0] ln;
		logic [31:0] flip;
		nrec = $urandom_range(3, 1);
		for (int k = 0; k < nrec; k++) begin
			sel = $urandom_range(99);
			mg = pr_magic;
			flip = '0;
			npay = pick_len();
			ln = npay;
			if (sel < 8) begin
				mg = mg ^ (32'h1 << $urandom_range(31));
			end else if (sel < 16) begin
				ln = too_long_len();
				npay = $urandom_range(4);
			end else if (sel < 24) begin
				flip = 32'h1 << $urandom_range(31);
			end
			if (sel >= 24 && sel < 28)
				add_noise($urandom_range(8, 1));
			else
				add_record(mg, $urandom, {$urandom, $urandom}, ln, npay, flip);
			if (sel < 28)
				break;
		end
		cut = frame_q.size();
		if ($urandom_range(99) < 12) begin
			cut = $urandom_range(frame_q.size(), 1);
		end else if ($urandom_range(99) < 10) begin
			add_noise($urandom_range(6, 1));
			cut = frame_q.size();
		end
		send_frame(cut);
	endtask

	// Reset values: magic zero, limit exactly 1 MiB
	task automatic test_register_defaults();
		add_record(32'h0, $urandom, {$urandom, $urandom}, 32'd0, 0, 32'h0);
		send_frame(frame_q.size());
		add_record(32'h0, $urandom, {$urandom, $urandom}, 32'h0010_0001, 0, 32'h0);
		send_frame(frame_q.size());
		add_record(32'h0, $urandom, {$urandom, $urandom}, 32'h0010_0000, 3, 32'h0);
		send_frame(23);
	endtask

	// Several good records in one buffer, field extremes included
	task automatic test_good_records();
		write_reg(jrd_pkg::CFG_RECORD_MAGIC, 32'hFFFF_FFFF);
		write_reg(jrd_pkg::CFG_MAX_LENGTH, 32'h00FF_FFFF);
		add_record(pr_magic, 32'h0, 64'h0, 32'd0, 0, 32'h0);
		add_record(pr_magic, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 1, 32'h0);
		add_record(pr_magic, $urandom, {$urandom, $urandom}, 32'd5, 5, 32'h0);
		send_frame(frame_q.size());
	endtask

	// Wrong magic, inside a buffer and on its last byte
	task automatic test_magic_check();
		write_reg(jrd_pkg::CFG_RECORD_MAGIC, $urandom);
		add_record(pr_magic ^ 32'h8000_0000, $urandom, {$urandom, $urandom}, 32'd2, 2,
			32'h0);
		send_frame(frame_q.size());
		add_record(pr_magic ^ 32'h1, $urandom, {$urandom, $urandom}, 32'd0, 0, 32'h0);
		send_frame(4);
	endtask

	// Length at, just over and far over the limit, at both limit extremes
	task automatic test_length_limit();
		write_reg(jrd_pkg::CFG_MAX_LENGTH, 32'd5);
		add_record(pr_magic, $urandom, {$urandom, $urandom}, 32'd5, 5, 32'h0);
		add_record(pr_magic, $urandom, {$urandom, $urandom}, 32'd6, 0, 32'h0);
		send_frame(frame_q.size());
		add_record(pr_magic, $urandom, {$urandom, $urandom}, 32'd6, 0, 32'h0);
		send_frame(20);
		write_reg(jrd_pkg::CFG_MAX_LENGTH, 32'hFF00_0000);
		add_record(pr_magic, $urandom, {$urandom, $urandom}, 32'd0, 0, 32'h0);
		add_record(pr_magic, $urandom, {$urandom, $urandom}, 32'd1, 1, 32'h0);
		send_frame(frame_q.size());
		write_reg(jrd_pkg::CFG_MAX_LENGTH, 32'h00FF_FFFF);
		add_record(pr_magic, $urandom, {$urandom, $urandom}, 32'hFFFF_FFFF, 0, 32'h0);
		send_frame(frame_q.size());
		add_record(pr_magic, $urandom, {$urandom, $urandom}, 32'h00FF_FFFF, 2, 32'h0);
		send_frame(22);
	endtask

	// Bad trailer on the last byte and mid-buffer; next buffer starts clean
	task automatic test_crc_check();
		add_record(pr_magic, $urandom, {$urandom, $urandom}, 32'd3, 3,
			32'h1 << $urandom_range(31));
		send_frame(frame_q.size());
		add_record(pr_magic, $urandom, {$urandom, $urandom}, 32'd1, 1, 32'h0000_0100);
		add_noise(3);
		send_frame(frame_q.size());
		add_record(pr_magic, $urandom, {$urandom, $urandom}, 32'd2, 2, 32'h0);
		send_frame(frame_q.size());
	endtask

	// Buffers cut in header, right after it, in payload and in trailer
	task automatic test_truncation();
		add_noise(1);
		send_frame(1);
		add_record(pr_magic, $urandom, {$urandom, $urandom}, 32'd4, 4, 32'h0);
		send_frame(20);
		add_record(pr_magic, $urandom, {$urandom, $urandom}, 32'd0, 0, 32'h0);
		send_frame(20);
		add_record(pr_magic, $urandom, {$urandom, $urandom}, 32'd3, 3, 32'h0);
		send_frame(22);
		add_record(pr_magic, $urandom, {$urandom, $urandom}, 32'd2, 2, 32'h0);
		send_frame(24);
		add_record(pr_magic, $urandom, {$urandom, $urandom}, 32'd1, 1, 32'h0);
		add_noise(1);
		send_frame(frame_q.size());
	endtask

	// Hold the result side for a long stretch while bytes keep coming
	task automatic test_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_ticket <= hold_ticket + 1;
		for (int k = 0; k < 8; k++)
			add_record(pr_magic, $urandom, {$urandom, $urandom}, 32'd24, 24, 32'h0);
		send_frame(frame_q.size());
	endtask

	task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_bytes,
			input logic [jrd_pkg::LEN_W-1:0] max_len);
		int start;
		write_reg(jrd_pkg::CFG_RECORD_MAGIC, $urandom);
		write_reg(jrd_pkg::CFG_MAX_LENGTH, {8'($urandom_range(255)), max_len});
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		start = bytes_in;
		while (bytes_in - start < n_bytes)
			random_buffer();
	endtask

	initial begin
		byte_if.valid = 1'b0;
		byte_if.data_byte = '0;
		byte_if.end_of_buffer = 1'b0;
		res_if.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = jrd_pkg::CFG_RECORD_MAGIC;
		cfg_wdata = '0;
		arst_n = 1'b0;
		pr_magic = jrd_pkg::MAGIC_RESET;
		pr_max = jrd_pkg::MAX_LEN_RESET;
		clear_parser();
		tx_idle_pct = 25;
		rx_idle_pct = 25;
		hold_ticket = 0;
		hold_served = 0;
		hold_left = 0;
		bad_results = 0;
		bytes_in = 0;
		input_stalls = 0;
		foreach (kind_count[i])
			kind_count[i] = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_register_defaults();
		test_good_records();
		test_magic_check();
		test_length_limit();
		test_crc_check();
		test_truncation();
		test_backpressure();
		test_random_traffic(36, 87, 260, 24'hFF_FFFF);
		test_random_traffic(87, 36, 260, 24'($urandom_range(40, 6)));
		test_random_traffic(0, 0, 260, 24'd12);

		// Drain and let any stray result show up
		byte_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("tb: %0d bytes sent; %0d payload bytes, %0d good records, %0d buffer ends",
			bytes_in, kind_count[jrd_pkg::KIND_PAYLOAD], kind_count[jrd_pkg::KIND_GOOD],
			kind_count[jrd_pkg::KIND_BUF_END]);
		$display("tb: errors seen: magic %0d, length %0d, crc %0d, truncated %0d; %0d stalls",
			kind_count[jrd_pkg::KIND_BAD_MAGIC], kind_count[jrd_pkg::KIND_TOO_LONG],
			kind_count[jrd_pkg::KIND_CRC_ERR], kind_count[jrd_pkg::KIND_TRUNCATED],
			input_stalls);
		if (bad_results == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Watchdog
	initial begin
		#12_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
